FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AAR_ASSERT(lbl, clk, rst_n, prop, msg)
`define AAR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/aar_pkg.sv
package aar_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int ATAN_LEN         = 24;

    localparam int ANG_W     = 33;
    localparam int CS_W      = 33;
    localparam int SUMSQ_W   = 32;
    localparam int SQ_W      = 31;
    localparam int RAD_SHIFT = 28;
    localparam int RAD_W     = SUMSQ_W + RAD_SHIFT;
    localparam int ROOT_W    = 30;
    localparam int QUO_W     = 31;
    localparam int REM_W     = ROOT_W + 1;
    // Dividend is |v| * 2^44; the first partial remainder is that over 2^QUO_W.
    localparam int DIV_PRESHIFT = 44 - QUO_W;
    localparam int UNIT_W    = 32;
    localparam int ACC_W     = 36;
    localparam int Q30_SHIFT = 30;
    localparam int Q14_SHIFT = 16;

    localparam logic signed [ANG_W-1:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [CS_W-1:0]  GAIN_Q30    = 33'sd652032874;
    localparam logic signed [CS_W-1:0]  ONE_Q30     = 33'sd1073741824;
    localparam logic [QUO_W-1:0]        QUO_ONE     = 31'h4000_0000;
    localparam logic signed [ACC_W-1:0] ROUND_Q14   = 36'sd32768;
    localparam logic signed [15:0]      ELEM_MAX    = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } aar_in_t;

    typedef struct packed {
        logic signed [15:0] row0_col0;
        logic signed [15:0] row0_col1;
        logic signed [15:0] row0_col2;
        logic signed [15:0] row1_col0;
        logic signed [15:0] row1_col1;
        logic signed [15:0] row1_col2;
        logic signed [15:0] row2_col0;
        logic signed [15:0] row2_col1;
        logic signed [15:0] row2_col2;
        logic               no_rotation;
    } aar_out_t;

    // Classified item handed from the front end to the arithmetic back end.
    typedef struct packed {
        logic                     zero_axis;
        logic                     single_axis;
        logic                     flip;
        logic signed [ANG_W-1:0]  z;
        logic signed [15:0]       axis_x;
        logic signed [15:0]       axis_y;
        logic signed [15:0]       axis_z;
        logic [SUMSQ_W-1:0]       sumsq;
    } aar_job_t;

    function automatic logic signed [ANG_W-1:0] atan_q28(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 33'sd210828714;
            1:       v = 33'sd124459457;
            2:       v = 33'sd65760959;
            3:       v = 33'sd33381290;
            4:       v = 33'sd16755423;
            5:       v = 33'sd8385879;
            6:       v = 33'sd4193963;
            7:       v = 33'sd2097109;
            8:       v = 33'sd1048571;
            9:       v = 33'sd524287;
            10:      v = 33'sd262144;
            11:      v = 33'sd131072;
            12:      v = 33'sd65536;
            13:      v = 33'sd32768;
            14:      v = 33'sd16384;
            15:      v = 33'sd8192;
            16:      v = 33'sd4096;
            17:      v = 33'sd2048;
            18:      v = 33'sd1024;
            19:      v = 33'sd512;
            20:      v = 33'sd256;
            21:      v = 33'sd128;
            22:      v = 33'sd64;
            23:      v = 33'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/aar_front.sv
module aar_front
    import aar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  aar_in_t  in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output aar_job_t job
);

    logic adv;

    logic                    f1_valid_reg;
    logic signed [ANG_W-1:0] f1_z_reg, f1_z_next;
    logic signed [15:0]      f1_ax_reg, f1_ay_reg, f1_az_reg;
    logic [SQ_W-1:0]         f1_sqx_reg, f1_sqy_reg, f1_sqz_reg;
    logic [SQ_W-1:0]         f1_sqx_next, f1_sqy_next, f1_sqz_next;

    logic                    job_valid_reg;
    aar_job_t                job_reg, job_next;

    logic signed [ANG_W-1:0] z0;
    logic signed [31:0]      sqx_full, sqy_full, sqz_full;
    logic                    nzx, nzy, nzz;

    assign adv      = !job_valid_reg || job_ready;
    assign in_ready = adv;

    // Stage one: first wrap of the angle into [-pi, pi] and the three squares.
    always_comb
    begin
        z0 = {in_data.angle[15], in_data.angle, 16'h0000};
        if (z0 > PI_Q28)
        begin
            f1_z_next = z0 - TWO_PI_Q28;
        end
        else if (z0 < -PI_Q28)
        begin
            f1_z_next = z0 + TWO_PI_Q28;
        end
        else
        begin
            f1_z_next = z0;
        end
        sqx_full    = in_data.axis_x * in_data.axis_x;
        sqy_full    = in_data.axis_y * in_data.axis_y;
        sqz_full    = in_data.axis_z * in_data.axis_z;
        f1_sqx_next = sqx_full[SQ_W-1:0];
        f1_sqy_next = sqy_full[SQ_W-1:0];
        f1_sqz_next = sqz_full[SQ_W-1:0];
    end

    // Stage two: fold into [-pi/2, pi/2], classify the axis, sum the squares.
    always_comb
    begin
        nzx = |f1_ax_reg;
        nzy = |f1_ay_reg;
        nzz = |f1_az_reg;
        job_next             = '0;
        job_next.zero_axis   = !(nzx || nzy || nzz);
        job_next.single_axis = (nzx ^ nzy ^ nzz) && !(nzx && nzy && nzz);
        job_next.axis_x      = f1_ax_reg;
        job_next.axis_y      = f1_ay_reg;
        job_next.axis_z      = f1_az_reg;
        job_next.sumsq       = SUMSQ_W'(f1_sqx_reg) + SUMSQ_W'(f1_sqy_reg)
                             + SUMSQ_W'(f1_sqz_reg);
        if (f1_z_reg > HALF_PI_Q28)
        begin
            job_next.z    = f1_z_reg - PI_Q28;
            job_next.flip = 1'b1;
        end
        else if (f1_z_reg < -HALF_PI_Q28)
        begin
            job_next.z    = f1_z_reg + PI_Q28;
            job_next.flip = 1'b1;
        end
        else
        begin
            job_next.z    = f1_z_reg;
            job_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg  <= in_valid;
            job_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_z_reg   <= f1_z_next;
            f1_ax_reg  <= in_data.axis_x;
            f1_ay_reg  <= in_data.axis_y;
            f1_az_reg  <= in_data.axis_z;
            f1_sqx_reg <= f1_sqx_next;
            f1_sqy_reg <= f1_sqy_next;
            f1_sqz_reg <= f1_sqz_next;
            job_reg    <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

FILE: sv/aar_queue.sv
`include "assert_macros.svh"

module aar_queue
    import aar_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  aar_job_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output aar_job_t out_data
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aar_job_t         mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `AAR_ASSERT_ALWAYS(a_count_range, clk, !rst_n || count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `AAR_ASSERT(a_count_up, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1), "queue count missed a push")
    `AAR_ASSERT(a_count_down, clk, rst_n, pop && !push |=> count_reg == $past(count_reg) - CNT_W'(1), "queue count missed a pop")

endmodule

FILE: sv/aar_back.sv
`include "assert_macros.svh"

module aar_back
    import aar_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  aar_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output aar_out_t out_data
);

    localparam int NA   = ROOT_W;
    localparam int NB   = QUO_W;
    localparam int NST  = NA + NB + 4;
    localparam int LAST = NST - 1;

    // Square root rows, with the CORDIC riding along in the first stages.
    typedef struct packed {
        logic                    zero;
        logic                    single;
        logic                    flip;
        logic signed [ANG_W-1:0] z;
        logic signed [CS_W-1:0]  x;
        logic signed [CS_W-1:0]  y;
        logic signed [15:0]      ax;
        logic signed [15:0]      ay;
        logic signed [15:0]      az;
        logic [RAD_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
    } sq_t;

    // Three restoring dividers in lockstep, lane 0 is x.
    typedef struct packed {
        logic                    zero;
        logic                    single;
        logic [2:0]              nzv;
        logic [2:0]              neg;
        logic signed [CS_W-1:0]  s;
        logic signed [CS_W-1:0]  c;
        logic [ROOT_W-1:0]       root;
        logic [2:0][REM_W-1:0]   rem;
        logic [2:0][QUO_W-1:0]   quo;
    } dv_t;

    typedef struct packed {
        logic                    zero;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
        logic signed [CS_W-1:0]  oc;
        logic signed [CS_W-1:0]  c;
        logic signed [CS_W-1:0]  s;
    } un_t;

    typedef struct packed {
        logic                    zero;
        logic signed [ACC_W-1:0] uxx, uyy, uzz, uxy, uyz, uzx;
        logic signed [ACC_W-1:0] xs, ys, zs;
        logic signed [CS_W-1:0]  oc;
        logic signed [CS_W-1:0]  c;
    } pp_t;

    typedef struct packed {
        logic                    zero;
        logic signed [ACC_W-1:0] oxx, oyy, ozz, oxy, oyz, ozx;
        logic signed [ACC_W-1:0] xs, ys, zs;
        logic signed [CS_W-1:0]  c;
    } po_t;

    function automatic logic signed [ACC_W-1:0] mulq30(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [2*ACC_W-1:0] p;
        p = a * b;
        return ACC_W'(p >>> Q30_SHIFT);
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [ACC_W-1:0] e);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] r;
        t = e + ROUND_Q14;
        r = t >>> Q14_SHIFT;
        if (r > ACC_W'(ELEM_MAX))
        begin
            r = ACC_W'(ELEM_MAX);
        end
        else if (r < -ACC_W'(ELEM_MAX))
        begin
            r = -ACC_W'(ELEM_MAX);
        end
        return r[15:0];
    endfunction

    logic           adv;
    logic [NST-1:0] vld_reg, vld_next;

    sq_t      sq_init;
    sq_t      sq_reg  [NA];
    sq_t      sq_next [NA];
    dv_t      dv_init;
    dv_t      dv_reg  [NB];
    dv_t      dv_next [NB];
    un_t      un_reg, un_next;
    pp_t      pp_reg, pp_next;
    po_t      po_reg, po_next;
    aar_out_t out_reg, out_next;

    assign adv       = !vld_reg[LAST] || out_ready;
    assign job_ready = adv;
    assign vld_next  = {vld_reg[NST-2:0], job_valid};

    always_comb
    begin
        sq_init        = '0;
        sq_init.zero   = job.zero_axis;
        sq_init.single = job.single_axis;
        sq_init.flip   = job.flip;
        sq_init.z      = job.z;
        sq_init.x      = GAIN_Q30;
        sq_init.y      = '0;
        sq_init.ax     = job.axis_x;
        sq_init.ay     = job.axis_y;
        sq_init.az     = job.axis_z;
        sq_init.rem    = {job.sumsq, {RAD_SHIFT{1'b0}}};
        sq_init.root   = '0;
    end

    for (genvar k = 0; k < NA; k++)
    begin : g_sq
        localparam int B = NA - 1 - k;
        sq_t          prv;
        logic [RAD_W:0] cand;

        if (k == 0)
        begin : g_first
            assign prv = sq_init;
        end
        else
        begin : g_rest
            assign prv = sq_reg[k-1];
        end

        always_comb
        begin
            sq_next[k] = prv;
            // One root bit per stage: try root + 2^B against the remainder.
            cand = ((RAD_W+1)'(prv.root) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
            if ({1'b0, prv.rem} >= cand)
            begin
                sq_next[k].rem     = prv.rem - cand[RAD_W-1:0];
                sq_next[k].root[B] = 1'b1;
            end
            if (k < CORDIC_STEPS && k < ATAN_LEN)
            begin
                if (!prv.z[ANG_W-1])
                begin
                    sq_next[k].x = prv.x - (prv.y >>> k);
                    sq_next[k].y = prv.y + (prv.x >>> k);
                    sq_next[k].z = prv.z - atan_q28(k);
                end
                else
                begin
                    sq_next[k].x = prv.x + (prv.y >>> k);
                    sq_next[k].y = prv.y - (prv.x >>> k);
                    sq_next[k].z = prv.z + atan_q28(k);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    always_comb
    begin
        logic [2:0][15:0] axv;
        logic [15:0]      mag;
        axv            = {sq_reg[NA-1].az, sq_reg[NA-1].ay, sq_reg[NA-1].ax};
        dv_init        = '0;
        dv_init.zero   = sq_reg[NA-1].zero;
        dv_init.single = sq_reg[NA-1].single;
        dv_init.root   = sq_reg[NA-1].root;
        dv_init.c      = sq_reg[NA-1].flip ? -sq_reg[NA-1].x : sq_reg[NA-1].x;
        dv_init.s      = sq_reg[NA-1].flip ? -sq_reg[NA-1].y : sq_reg[NA-1].y;
        for (int l = 0; l < 3; l++)
        begin
            mag             = axv[l][15] ? (16'd0 - axv[l]) : axv[l];
            dv_init.neg[l]  = axv[l][15];
            dv_init.nzv[l]  = |axv[l];
            dv_init.rem[l]  = REM_W'({mag, {DIV_PRESHIFT{1'b0}}});
            dv_init.quo[l]  = '0;
        end
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_dv
        localparam int Q = NB - 1 - j;
        dv_t prv;

        if (j == 0)
        begin : g_first
            assign prv = dv_init;
        end
        else
        begin : g_rest
            assign prv = dv_reg[j-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] r2;
            dv_next[j] = prv;
            for (int l = 0; l < 3; l++)
            begin
                r2 = {prv.rem[l][REM_W-2:0], 1'b0};
                if (r2 >= {1'b0, prv.root})
                begin
                    dv_next[j].rem[l]    = r2 - {1'b0, prv.root};
                    dv_next[j].quo[l][Q] = 1'b1;
                end
                else
                begin
                    dv_next[j].rem[l] = r2;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    // Unit axis: clamp the quotients to one and restore signs, or take plus or minus one for a single-component axis.
    always_comb
    begin
        logic [2:0][UNIT_W-1:0] uv;
        logic [QUO_W-1:0]       qc;
        qc = '0;
        for (int l = 0; l < 3; l++)
        begin
            if (dv_reg[NB-1].single)
            begin
                if (!dv_reg[NB-1].nzv[l])
                begin
                    uv[l] = '0;
                end
                else
                begin
                    uv[l] = dv_reg[NB-1].neg[l] ? UNIT_W'(-ONE_Q30) : UNIT_W'(ONE_Q30);
                end
            end
            else
            begin
                qc    = (dv_reg[NB-1].quo[l] > QUO_ONE) ? QUO_ONE : dv_reg[NB-1].quo[l];
                uv[l] = dv_reg[NB-1].neg[l] ? (UNIT_W'(0) - UNIT_W'(qc)) : UNIT_W'(qc);
            end
        end
        un_next      = '0;
        un_next.zero = dv_reg[NB-1].zero;
        un_next.ux   = uv[0];
        un_next.uy   = uv[1];
        un_next.uz   = uv[2];
        un_next.oc   = ONE_Q30 - dv_reg[NB-1].c;
        un_next.c    = dv_reg[NB-1].c;
        un_next.s    = dv_reg[NB-1].s;
    end

    always_comb
    begin
        pp_next      = '0;
        pp_next.zero = un_reg.zero;
        pp_next.uxx  = mulq30(ACC_W'(un_reg.ux), ACC_W'(un_reg.ux));
        pp_next.uyy  = mulq30(ACC_W'(un_reg.uy), ACC_W'(un_reg.uy));
        pp_next.uzz  = mulq30(ACC_W'(un_reg.uz), ACC_W'(un_reg.uz));
        pp_next.uxy  = mulq30(ACC_W'(un_reg.ux), ACC_W'(un_reg.uy));
        pp_next.uyz  = mulq30(ACC_W'(un_reg.uy), ACC_W'(un_reg.uz));
        pp_next.uzx  = mulq30(ACC_W'(un_reg.uz), ACC_W'(un_reg.ux));
        pp_next.xs   = mulq30(ACC_W'(un_reg.ux), ACC_W'(un_reg.s));
        pp_next.ys   = mulq30(ACC_W'(un_reg.uy), ACC_W'(un_reg.s));
        pp_next.zs   = mulq30(ACC_W'(un_reg.uz), ACC_W'(un_reg.s));
        pp_next.oc   = un_reg.oc;
        pp_next.c    = un_reg.c;
    end

    always_comb
    begin
        po_next      = '0;
        po_next.zero = pp_reg.zero;
        po_next.oxx  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uxx);
        po_next.oyy  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uyy);
        po_next.ozz  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uzz);
        po_next.oxy  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uxy);
        po_next.oyz  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uyz);
        po_next.ozx  = mulq30(ACC_W'(pp_reg.oc), pp_reg.uzx);
        po_next.xs   = pp_reg.xs;
        po_next.ys   = pp_reg.ys;
        po_next.zs   = pp_reg.zs;
        po_next.c    = pp_reg.c;
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] cw;
        cw = ACC_W'(po_reg.c);
        if (po_reg.zero)
        begin
            out_next             = '0;
            out_next.row0_col0   = ELEM_MAX;
            out_next.row1_col1   = ELEM_MAX;
            out_next.row2_col2   = ELEM_MAX;
            out_next.no_rotation = 1'b1;
        end
        else
        begin
            out_next.row0_col0   = to_q14(po_reg.oxx + cw);
            out_next.row0_col1   = to_q14(po_reg.oxy - po_reg.zs);
            out_next.row0_col2   = to_q14(po_reg.ozx + po_reg.ys);
            out_next.row1_col0   = to_q14(po_reg.oxy + po_reg.zs);
            out_next.row1_col1   = to_q14(po_reg.oyy + cw);
            out_next.row1_col2   = to_q14(po_reg.oyz - po_reg.xs);
            out_next.row2_col0   = to_q14(po_reg.ozx - po_reg.ys);
            out_next.row2_col1   = to_q14(po_reg.oyz + po_reg.xs);
            out_next.row2_col2   = to_q14(po_reg.ozz + cw);
            out_next.no_rotation = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            un_reg  <= un_next;
            pp_reg  <= pp_next;
            po_reg  <= po_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[LAST];
    assign out_data  = out_reg;

    `AAR_ASSERT(a_stall_freezes, clk, rst_n, !adv |=> $stable(vld_reg), "pipeline moved during a stall")
    `AAR_ASSERT(a_identity, clk, rst_n, out_valid && out_data.no_rotation |-> out_data.row0_col0 == ELEM_MAX && out_data.row0_col1 == 16'sd0, "zero axis did not give identity")
    `AAR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while waiting")

endmodule

FILE: sv/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix. Each input beat carries an angle in
// radians (signed Q3.12) and an axis (three signed Q4.11 components of any
// length); each output beat carries the nine elements of the rotation block,
// row-major, in signed Q1.14 saturated to plus or minus one, plus a
// no_rotation flag that is set, with the identity matrix, when the axis is
// all zero. The fourth row and column of the full 4x4 matrix are identity
// and are not carried. A front end reduces the angle to [-pi/2, pi/2],
// squares and sums the axis and classifies it (zero, single component, or
// general); a small queue of QUEUE_DEPTH beats decouples it from the back
// end. The back end is a single pipeline: 30 square-root stages (with the
// CORDIC_STEPS sine/cosine iterations sharing the first of them), 31
// restoring-divide stages that normalize all three components in parallel,
// then unit clamp, two multiply stages and a round/saturate output register.
// One beat is accepted per clock unless back-pressure has filled the queue.
// With no back-pressure an accepted beat passes through the front-end
// registers, one queue entry and the 65 back-end stages before out_valid
// rises; when the output is not taken the whole back-end pipeline holds and
// the queue absorbs further beats until it fills.
module axis_angle_rotation_matrix
    import aar_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  aar_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output aar_out_t out_data
);

    // Front end to queue.
    logic     fq_valid;
    logic     fq_ready;
    aar_job_t fq_job;

    // Queue to back end.
    logic     qb_valid;
    logic     qb_ready;
    aar_job_t qb_job;

    aar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    aar_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_job)
    );

    aar_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: tb/sv/aar_checker.sv
`timescale 1ns / 100ps

module aar_checker
    import aar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  aar_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  aar_out_t out_data,
    output int       errors,
    output int       pending
);

    localparam int STEPS = CORDIC_STEPS_DEF;

    aar_out_t matrix_q[$];
    int       err_count = 0;

    assign errors = err_count;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_elem(longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return 16'(r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint v, longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = (mag << 44) / r;
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic aar_out_t rotation_of(aar_in_t b);
        aar_out_t m;
        longint ax, ay, az, z, x, y, nx, s, c, ux, uy, uz, oc;
        longint xs, ys, zs, xy, yz, zx;
        longint unsigned r;
        bit flip;
        int nz;
        m = '0;
        ax = b.axis_x;
        ay = b.axis_y;
        az = b.axis_z;
        nz = (ax != 0) + (ay != 0) + (az != 0);
        if (nz == 0)
        begin
            m.row0_col0 = ELEM_MAX;
            m.row1_col1 = ELEM_MAX;
            m.row2_col2 = ELEM_MAX;
            m.no_rotation = 1'b1;
            return m;
        end
        // Angle reduction to [-pi/2, pi/2], then rotation-mode CORDIC.
        z = longint'(b.angle) * 65536;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (z > PI_Q28)
            z = z - TWO_PI_Q28;
        else if (z < -PI_Q28)
            z = z + TWO_PI_Q28;
        if (z > HALF_PI_Q28)
        begin
            z = z - PI_Q28;
            flip = 1;
        end
        else if (z < -HALF_PI_Q28)
        begin
            z = z + PI_Q28;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - atan_q28(i);
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + atan_q28(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        if (nz == 1)
        begin
            ux = (ax == 0) ? 0 : ((ax < 0) ? -(64'sd1 << 30) : (64'sd1 << 30));
            uy = (ay == 0) ? 0 : ((ay < 0) ? -(64'sd1 << 30) : (64'sd1 << 30));
            uz = (az == 0) ? 0 : ((az < 0) ? -(64'sd1 << 30) : (64'sd1 << 30));
        end
        else
        begin
            r = int_sqrt(longint'(ax * ax + ay * ay + az * az) << 28);
            ux = unit_part(ax, r);
            uy = unit_part(ay, r);
            uz = unit_part(az, r);
        end
        oc = (64'sd1 << 30) - c;
        xs = mul_q30(ux, s);
        ys = mul_q30(uy, s);
        zs = mul_q30(uz, s);
        xy = mul_q30(oc, mul_q30(ux, uy));
        yz = mul_q30(oc, mul_q30(uy, uz));
        zx = mul_q30(oc, mul_q30(uz, ux));
        m.row0_col0 = round_elem(mul_q30(oc, mul_q30(ux, ux)) + c);
        m.row0_col1 = round_elem(xy - zs);
        m.row0_col2 = round_elem(zx + ys);
        m.row1_col0 = round_elem(xy + zs);
        m.row1_col1 = round_elem(mul_q30(oc, mul_q30(uy, uy)) + c);
        m.row1_col2 = round_elem(yz - xs);
        m.row2_col0 = round_elem(zx - ys);
        m.row2_col1 = round_elem(yz + xs);
        m.row2_col2 = round_elem(mul_q30(oc, mul_q30(uz, uz)) + c);
        return m;
    endfunction

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            err_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        aar_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                matrix_q.push_back(rotation_of(in_data));
            if (out_valid && out_ready)
            begin
                if (matrix_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected output beat %h", $time, out_data);
                end
                else
                begin
                    want = matrix_q.pop_front();
                    compare_field("row0_col0", want.row0_col0, out_data.row0_col0);
                    compare_field("row0_col1", want.row0_col1, out_data.row0_col1);
                    compare_field("row0_col2", want.row0_col2, out_data.row0_col2);
                    compare_field("row1_col0", want.row1_col0, out_data.row1_col0);
                    compare_field("row1_col1", want.row1_col1, out_data.row1_col1);
                    compare_field("row1_col2", want.row1_col2, out_data.row1_col2);
                    compare_field("row2_col0", want.row2_col0, out_data.row2_col0);
                    compare_field("row2_col1", want.row2_col1, out_data.row2_col1);
                    compare_field("row2_col2", want.row2_col2, out_data.row2_col2);
                    compare_field("no_rotation", want.no_rotation, out_data.no_rotation);
                end
            end
        end
        pending <= matrix_q.size();
    end

endmodule

FILE: tb/sv/tb_axis_angle_rotation_matrix.sv
`timescale 1ns / 100ps

module tb_axis_angle_rotation_matrix;
    import aar_pkg::*;

    localparam int LATENCY      = 68;
    localparam int RANDOM_BEATS = 1130;
    localparam int CYCLE_LIMIT  = 400000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    aar_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    aar_out_t out_data;
    int       errors;
    int       pending;
    int       cycles = 0;
    // Set while the receiver is in its long hold-off, so the sender keeps
    // offering beats and the internal queue fills and stalls the input.
    bit       hold_rx = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    axis_angle_rotation_matrix i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    aar_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .pending  (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 90);
    endfunction

    // Watchdog: a generous cycle count ends a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked for.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
                out_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                stall = gap_length();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Drive one beat at the falling edge and hold it until it is taken.
    task automatic send_beat(aar_in_t b);
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_gap();
        int n;
        n = gap_length();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic logic signed [15:0] any_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'sh7FFF;
        if (pick == 1)
            return 16'sh8000;
        if (pick == 2)
            return 16'(signed'($urandom_range(0, 15)) - 8);
        return 16'($urandom);
    endfunction

    function automatic aar_in_t random_beat();
        aar_in_t b;
        int shape;
        b.angle  = any_value();
        b.axis_x = any_value();
        b.axis_y = any_value();
        b.axis_z = any_value();
        // Some beats use a zero or single-component axis.
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            b.axis_x = '0;
            b.axis_y = '0;
            b.axis_z = '0;
        end
        else if (shape < 4)
        begin
            if (shape != 1) b.axis_x = '0;
            if (shape != 2) b.axis_y = '0;
            if (shape != 3) b.axis_z = '0;
        end
        else if (shape < 6)
            b.axis_y = '0;
        return b;
    endfunction

    task automatic send_directed();
        logic signed [15:0] angles [8];
        aar_in_t b;
        angles = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd6434, -16'sd6434,
                   16'sd12868, -16'sd12868, 16'sd3217};
        // Zero axis at both angle extremes.
        send_beat('{angle: 16'sh7FFF, axis_x: 0, axis_y: 0, axis_z: 0});
        send_beat('{angle: 16'sh8000, axis_x: 0, axis_y: 0, axis_z: 0});
        // Single-axis cases with both signs and extreme magnitudes.
        send_beat('{angle: angles[3], axis_x: 16'sh7FFF, axis_y: 0, axis_z: 0});
        send_beat('{angle: angles[4], axis_x: 0, axis_y: 16'sh8000, axis_z: 0});
        send_beat('{angle: angles[5], axis_x: 0, axis_y: 0, axis_z: 16'sd1});
        send_beat('{angle: angles[6], axis_x: -16'sd1, axis_y: 0, axis_z: 0});
        // Angle sweep across the reduction boundaries on a general axis.
        for (int i = 0; i < 8; i++)
        begin
            b = '{angle: angles[i], axis_x: 16'sd2048, axis_y: -16'sd2048,
                  axis_z: 16'sd1024};
            send_beat(b);
        end
        // Largest and smallest general axes, and alternating bit patterns.
        send_beat('{angle: 16'sd1000, axis_x: 16'sh8000, axis_y: 16'sh8000,
                    axis_z: 16'sh8000});
        send_beat('{angle: -16'sd1000, axis_x: 16'sh7FFF, axis_y: 16'sh7FFF,
                    axis_z: 16'sh7FFF});
        send_beat('{angle: 16'sd5000, axis_x: 16'sd1, axis_y: -16'sd1, axis_z: 0});
        send_beat('{angle: 16'sh7FFF, axis_x: 16'hFFFF, axis_y: 16'hFFFF,
                    axis_z: 16'hFFFF});
        send_beat('{angle: 16'sh5555, axis_x: 16'sh5555, axis_y: 16'shAAAA,
                    axis_z: 16'sh5555});
        send_beat('{angle: 16'shAAAA, axis_x: 16'shAAAA, axis_y: 16'sh5555,
                    axis_z: 16'shAAAA});
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int idle;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_directed();

        // The sender pauses until every expected beat has come back.
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // Long receiver hold-off while back-to-back beats keep being offered.
            if (n == 400)
            begin
                hold_rx = 1;
                fork
                    begin
                        repeat (200) @(negedge clk);
                        hold_rx = 0;
                    end
                join_none
            end
            if (n == 700)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_beat(random_beat());
            // Stretches of back-to-back beats between idling phases.
            if (!((n / 100) % 3 == 1))
                send_gap();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        idle = 0;
        while (idle < LATENCY + 20)
        begin
            @(negedge clk);
            idle++;
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/aar_pkg.sv
sv/aar_front.sv
sv/aar_queue.sv
sv/aar_back.sv
sv/axis_angle_rotation_matrix.sv
tb/sv/aar_checker.sv
tb/sv/tb_axis_angle_rotation_matrix.sv
